[rtl/swarq_pkg.sv]
// Package for the sliding window ARQ sender: widths, codes, payload and control types.
package swarq_pkg;

  localparam int unsigned SlotsDefault      = 8;
  localparam int unsigned MaxSegmentDefault = 1024;

  localparam int unsigned KindW     = 2;
  localparam int unsigned LenW      = 11;
  localparam int unsigned SeqW      = 32;
  localparam int unsigned WinW      = 16;
  localparam int unsigned AgeW      = 16;
  localparam int unsigned EvW       = 3;
  localparam int unsigned SlotFldW  = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [SeqW-1:0] StartSeqRst   = 32'd0;
  localparam logic [WinW-1:0] PeerWindowRst = 16'd4096;
  localparam logic [AgeW-1:0] RtoTicksRst   = 16'd100;

  typedef enum logic [KindW-1:0] {
    KIND_SEND = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [EvW-1:0] {
    EV_SENT       = 3'd0,
    EV_SLOTS_FULL = 3'd1,
    EV_FLOW_BLOCK = 3'd2,
    EV_EMPTY      = 3'd3,
    EV_ACK_ADV    = 3'd4,
    EV_ACK_STALE  = 3'd5,
    EV_RETRANSMIT = 3'd6,
    EV_IDLE_TICK  = 3'd7
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_SEQ   = 2'd0,
    CFG_PEER_WINDOW = 2'd1,
    CFG_RTO_TICKS   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [LenW-1:0]  segment_length;
    logic [SeqW-1:0]  ack_number;
    logic [WinW-1:0]  advertised_window;
  } in_t;

  typedef struct packed {
    logic [EvW-1:0]      event_res;
    logic [SlotFldW-1:0] slot;
    logic [SeqW-1:0]     seq;
    logic [LenW-1:0]     length;
    logic [SeqW-1:0]     window_base;
    logic [SeqW-1:0]     bytes_in_flight;
    logic                all_acked;
    logic                last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic kind_unused;
    logic stall;
    logic at_last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/sliding_window_arq_sender.sv]
// Top level of the sliding window ARQ sender: controller and datapath.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_ready_o    swarq_pkg::in_t (kind, length, ACK, window)
//  out      output     out_valid_o / out_ready_i  swarq_pkg::out_t (reports, the final one flagged last)
//  cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Each request visits every slot once, one slot per cycle unless the scan is held, then
// commits and, for a used kind, loads its final report into the output register; only
// then, with the controller back in idle, is the next request taken. A tick that finds
// a timeout while an earlier report still waits in the output register holds the scan
// until it drains, and the final report likewise waits for the output register to free.
// Reset is asynchronous and clears the slot lengths, done bits and ages directly, so
// the block takes requests as soon as reset is released, with no clearing pass.
// The output register lets a new request enter while the last report waits.
module sliding_window_arq_sender #(
  parameter int unsigned SLOTS       = swarq_pkg::SlotsDefault,
  parameter int unsigned MAX_SEGMENT = swarq_pkg::MaxSegmentDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  swarq_pkg::in_t                 in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output swarq_pkg::out_t                out_o,
  input  logic                           cfg_we_i,
  input  logic [swarq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [swarq_pkg::CfgDataW-1:0] cfg_data_i
);

  // The controller only sequences; all state of the window lives in the datapath.
  swarq_pkg::ctl_cmd_t   cmd;
  swarq_pkg::dp_status_t status;

  swarq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // The datapath stages each timeout report one step behind, so that the final
  // report of a tick can carry the last flag once the scan has finished.
  swarq_dp #(
    .SLOTS       (SLOTS),
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

[rtl/swarq_dp.sv]
// Datapath of the ARQ sender: slot table, window registers, result staging and output register.
module swarq_dp #(
  parameter int unsigned SLOTS       = swarq_pkg::SlotsDefault,
  parameter int unsigned MAX_SEGMENT = swarq_pkg::MaxSegmentDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swarq_pkg::ctl_cmd_t              cmd_i,
  output swarq_pkg::dp_status_t            status_o,
  input  logic                             in_valid_i,
  input  swarq_pkg::in_t                   in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output swarq_pkg::out_t                  out_o,
  input  logic                             cfg_we_i,
  input  logic [swarq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [swarq_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned UsedW = $clog2(SLOTS + 1);
  localparam int unsigned SegW  = 16;

  typedef logic [swarq_pkg::SeqW-1:0] seq_t;
  typedef logic [swarq_pkg::LenW-1:0] len_t;
  typedef logic [swarq_pkg::AgeW-1:0] age_t;

  // Configuration registers.
  seq_t                        start_seq_q, start_seq_d;
  logic [swarq_pkg::WinW-1:0]  init_peer_q, init_peer_d;
  age_t                        rto_q, rto_d;

  // Window state.
  seq_t                        base_q, base_d;
  seq_t                        next_q, next_d;
  logic [UsedW-1:0]            used_q, used_d;
  logic [swarq_pkg::WinW-1:0]  peer_q, peer_d;

  // Slot table.
  seq_t                        slot_seq_q  [SLOTS];
  seq_t                        slot_seq_d  [SLOTS];
  len_t                        slot_len_q  [SLOTS];
  len_t                        slot_len_d  [SLOTS];
  logic [SLOTS-1:0]            slot_done_q, slot_done_d;
  age_t                        slot_age_q  [SLOTS];
  age_t                        slot_age_d  [SLOTS];

  // Per-item working registers.
  swarq_pkg::in_t              in_q, in_d;
  logic                        ack_adv_q, ack_adv_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic                        free_found_q, free_found_d;
  logic [IdxW-1:0]             free_idx_q, free_idx_d;

  // Staged result, held back one report so that the final one can carry last.
  logic                        pend_valid_q, pend_valid_d;
  swarq_pkg::event_e           pend_ev_q, pend_ev_d;
  logic [IdxW-1:0]             pend_slot_q, pend_slot_d;
  seq_t                        pend_seq_q, pend_seq_d;
  len_t                        pend_len_q, pend_len_d;

  logic                        out_valid_q, out_valid_d;
  swarq_pkg::out_t             out_q, out_d;

  logic                        busy;
  seq_t                        seg_end;
  age_t                        age_inc;
  logic                        hit;
  logic                        out_free;
  logic                        step;
  len_t                        len_clamped;
  seq_t                        in_flight;
  swarq_pkg::out_t             staged;

  always_comb begin
    busy     = (slot_len_q[idx_q] != '0) && !slot_done_q[idx_q];
    seg_end  = slot_seq_q[idx_q] + seq_t'(slot_len_q[idx_q]);
    age_inc  = (slot_age_q[idx_q] == '1) ? slot_age_q[idx_q] : slot_age_q[idx_q] + age_t'(1);
    hit      = busy && (age_inc >= rto_q);
    out_free = !out_valid_q || out_ready_i;
    step     = cmd_i.scan && !status_o.stall;
    in_flight = next_q - base_q;
    if (SegW'(in_q.segment_length) > SegW'(MAX_SEGMENT)) begin
      len_clamped = len_t'(MAX_SEGMENT);
    end else begin
      len_clamped = in_q.segment_length;
    end
  end

  always_comb begin
    status_o.in_valid    = in_valid_i;
    status_o.kind_unused = (in_q.kind != swarq_pkg::KIND_SEND) &&
                           (in_q.kind != swarq_pkg::KIND_ACK) &&
                           (in_q.kind != swarq_pkg::KIND_TICK);
    status_o.stall       = (in_q.kind == swarq_pkg::KIND_TICK) && hit &&
                           pend_valid_q && !out_free;
    status_o.at_last     = (idx_q == IdxW'(SLOTS - 1));
    status_o.out_free    = out_free;
  end

  // Staged result as it would leave, with the window fields taken from the current registers.
  always_comb begin
    staged.event_res       = pend_ev_q;
    staged.slot            = swarq_pkg::SlotFldW'(pend_slot_q);
    staged.seq             = pend_seq_q;
    staged.length          = pend_len_q;
    staged.window_base     = base_q;
    staged.bytes_in_flight = in_flight;
    staged.all_acked       = (base_q == next_q);
    staged.last            = 1'b0;
  end

  always_comb begin
    start_seq_d  = start_seq_q;
    init_peer_d  = init_peer_q;
    rto_d        = rto_q;
    base_d       = base_q;
    next_d       = next_q;
    used_d       = used_q;
    peer_d       = peer_q;
    slot_seq_d   = slot_seq_q;
    slot_len_d   = slot_len_q;
    slot_done_d  = slot_done_q;
    slot_age_d   = slot_age_q;
    in_d         = in_q;
    ack_adv_d    = ack_adv_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    pend_valid_d = pend_valid_q;
    pend_ev_d    = pend_ev_q;
    pend_slot_d  = pend_slot_q;
    pend_seq_d   = pend_seq_q;
    pend_len_d   = pend_len_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swarq_pkg::CFG_START_SEQ: begin
          start_seq_d = cfg_data_i;
          base_d      = cfg_data_i;
          next_d      = cfg_data_i;
          used_d      = '0;
          slot_done_d = '0;
          for (int i = 0; i < SLOTS; i++) begin
            slot_len_d[i] = '0;
            slot_age_d[i] = '0;
          end
        end
        swarq_pkg::CFG_PEER_WINDOW: begin
          init_peer_d = cfg_data_i[swarq_pkg::WinW-1:0];
          peer_d      = cfg_data_i[swarq_pkg::WinW-1:0];
        end
        swarq_pkg::CFG_RTO_TICKS: begin
          rto_d = cfg_data_i[swarq_pkg::AgeW-1:0];
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.accept) begin
      in_d         = in_i;
      ack_adv_d    = in_i.ack_number > base_q;
      idx_d        = '0;
      free_found_d = 1'b0;
      pend_valid_d = 1'b0;
    end

    if (step) begin
      idx_d = idx_q + IdxW'(1);
      unique case (in_q.kind)
        swarq_pkg::KIND_SEND: begin
          if (!busy && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
        end
        swarq_pkg::KIND_ACK: begin
          if (ack_adv_q && busy && (seg_end <= in_q.ack_number)) begin
            slot_done_d[idx_q] = 1'b1;
            if (used_q != '0) begin
              used_d = used_q - UsedW'(1);
            end
          end
        end
        swarq_pkg::KIND_TICK: begin
          if (busy) begin
            if (hit) begin
              slot_age_d[idx_q] = '0;
              // A new timeout releases the report staged before it.
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_d       = staged;
              end
              pend_valid_d = 1'b1;
              pend_ev_d    = swarq_pkg::EV_RETRANSMIT;
              pend_slot_d  = idx_q;
              pend_seq_d   = slot_seq_q[idx_q];
              pend_len_d   = slot_len_q[idx_q];
            end else begin
              slot_age_d[idx_q] = age_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.commit) begin
      unique case (in_q.kind)
        swarq_pkg::KIND_SEND: begin
          pend_slot_d = '0;
          pend_seq_d  = '0;
          pend_len_d  = '0;
          if ((used_q >= UsedW'(SLOTS)) || !free_found_q) begin
            pend_ev_d = swarq_pkg::EV_SLOTS_FULL;
          end else if (in_flight >= seq_t'(peer_q)) begin
            pend_ev_d = swarq_pkg::EV_FLOW_BLOCK;
          end else if (len_clamped == '0) begin
            pend_ev_d = swarq_pkg::EV_EMPTY;
          end else begin
            slot_seq_d[free_idx_q]  = next_q;
            slot_len_d[free_idx_q]  = len_clamped;
            slot_done_d[free_idx_q] = 1'b0;
            slot_age_d[free_idx_q]  = '0;
            next_d      = next_q + seq_t'(len_clamped);
            used_d      = used_q + UsedW'(1);
            pend_ev_d   = swarq_pkg::EV_SENT;
            pend_slot_d = free_idx_q;
            pend_seq_d  = next_q;
            pend_len_d  = len_clamped;
          end
        end
        swarq_pkg::KIND_ACK: begin
          peer_d      = in_q.advertised_window;
          pend_slot_d = '0;
          pend_seq_d  = '0;
          pend_len_d  = '0;
          if (ack_adv_q) begin
            base_d    = in_q.ack_number;
            pend_ev_d = swarq_pkg::EV_ACK_ADV;
          end else begin
            pend_ev_d = swarq_pkg::EV_ACK_STALE;
          end
        end
        swarq_pkg::KIND_TICK: begin
          if (!pend_valid_q) begin
            pend_ev_d   = swarq_pkg::EV_IDLE_TICK;
            pend_slot_d = '0;
            pend_seq_d  = '0;
            pend_len_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_d       = staged;
      out_d.last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_seq_q  <= swarq_pkg::StartSeqRst;
      init_peer_q  <= swarq_pkg::PeerWindowRst;
      rto_q        <= swarq_pkg::RtoTicksRst;
      base_q       <= swarq_pkg::StartSeqRst;
      next_q       <= swarq_pkg::StartSeqRst;
      used_q       <= '0;
      peer_q       <= swarq_pkg::PeerWindowRst;
      slot_done_q  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_len_q[i] <= '0;
        slot_age_q[i] <= '0;
      end
      idx_q        <= '0;
      free_found_q <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      start_seq_q  <= start_seq_d;
      init_peer_q  <= init_peer_d;
      rto_q        <= rto_d;
      base_q       <= base_d;
      next_q       <= next_d;
      used_q       <= used_d;
      peer_q       <= peer_d;
      slot_done_q  <= slot_done_d;
      slot_len_q   <= slot_len_d;
      slot_age_q   <= slot_age_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_seq_q  <= slot_seq_d;
    in_q        <= in_d;
    ack_adv_q   <= ack_adv_d;
    free_idx_q  <= free_idx_d;
    pend_ev_q   <= pend_ev_d;
    pend_slot_q <= pend_slot_d;
    pend_seq_q  <= pend_seq_d;
    pend_len_q  <= pend_len_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[rtl/swarq_ctrl.sv]
// Controller of the ARQ sender: sequences accept, slot scan, commit and final report.
module swarq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swarq_pkg::dp_status_t status_i,
  output swarq_pkg::ctl_cmd_t   cmd_o,
  output logic                  in_ready_o
);

  swarq_pkg::ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swarq_pkg::ST_IDLE: begin
        if (status_i.in_valid) begin
          state_d = swarq_pkg::ST_SCAN;
        end
      end
      swarq_pkg::ST_SCAN: begin
        if (!status_i.stall && status_i.at_last) begin
          state_d = swarq_pkg::ST_COMMIT;
        end
      end
      swarq_pkg::ST_COMMIT: begin
        // An unused kind gives no result.
        if (status_i.kind_unused) begin
          state_d = swarq_pkg::ST_IDLE;
        end else begin
          state_d = swarq_pkg::ST_EMIT;
        end
      end
      swarq_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = swarq_pkg::ST_IDLE;
        end
      end
      default: state_d = swarq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == swarq_pkg::ST_IDLE);
    cmd_o.accept = (state_q == swarq_pkg::ST_IDLE) && status_i.in_valid;
    cmd_o.scan   = (state_q == swarq_pkg::ST_SCAN);
    cmd_o.commit = (state_q == swarq_pkg::ST_COMMIT);
    cmd_o.emit   = (state_q == swarq_pkg::ST_EMIT) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swarq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
